// ===== rtl/assert_macros.svh =====
// assertion macros used by the decimator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/pdmdec_pkg.sv =====
// types and constants of the pdm to pcm decimator
package pdmdec_pkg;

  localparam int PDM_W    = 8;
  localparam int PCM_W    = 13;
  localparam int WIN_CW   = 5;
  localparam int GAIN_W   = 7;
  localparam int WEIGHT_W = 8;
  localparam int CFG_W    = 8;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_WEIGHT = 2'd2;

  localparam logic [WIN_CW-1:0]   WINDOW_RST = 5'd8;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 7'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 8'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_GAIN,
    S_WEIGHT,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/pdm_to_pcm_decimator.sv =====
// pdm to pcm decimator: boxcar ones count, gain and one-pole iir, bit-serial datapath
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    s_tdata[7:0]  = pdm_byte
//   m_*       out        m_tvalid / m_tready    m_tdata[12:0] = pcm_sample
//   cfg_*     in         cfg_we                 cfg_index, cfg_data
//
// a byte is counted one bit per cycle; when it does not close the window, the next byte is
// taken on its last count cycle. a closing byte adds 7 gain steps, 8 weight steps, one
// divider step per quotient bit (29 at default parameters) and the done state, which waits
// for a free result register; then the block is idle again.
// reset is synchronous and clears all state at once. the result register holds a sample
// until taken; bytes keep coming meanwhile, only a second sample waits in the done state.
`include "assert_macros.svh"

module pdm_to_pcm_decimator #(
  parameter int MAX_WINDOW_BYTES = 16,
  parameter int FRACTION_BITS    = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pdmdec_pkg::PDM_W-1:0]   s_tdata,   // [7:0] pdm_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [12:0] pcm_sample, [15:13] zero
  input  logic                           cfg_we,
  input  logic [pdmdec_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pdmdec_pkg::CFG_W-1:0]   cfg_data
);
  import pdmdec_pkg::*;

  localparam int POS_W      = (MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1;
  localparam int WIN_W      = $clog2(MAX_WINDOW_BYTES + 1);
  localparam int ONES_W     = $clog2(8 * MAX_WINDOW_BYTES + 1);
  localparam int BIAS_W     = ONES_W + 1;
  localparam int SAMP_W     = BIAS_W + GAIN_W;
  localparam int FMAG_W     = 12 + FRACTION_BITS;
  localparam int FILT_W     = FMAG_W + 1;
  localparam int PROD_BITS  = FMAG_W + WEIGHT_W;
  localparam int SAMP_BITS  = SAMP_W - 1 + FRACTION_BITS;
  localparam int ACC_W      = ((PROD_BITS > SAMP_BITS) ? PROD_BITS : SAMP_BITS) + 2;
  localparam int QUO_W      = ACC_W - 1;
  localparam int DCNT_W     = $clog2(QUO_W);
  localparam logic [FMAG_W-1:0] LIMIT = FMAG_W'(4095 * (2 ** FRACTION_BITS));

  // configuration
  logic [WIN_CW-1:0]   window_bytes;
  logic [GAIN_W-1:0]   gain;
  logic [WEIGHT_W-1:0] smoothing_weight;

  state_t state, state_next;

  logic [PDM_W-1:0]        bit_sr;
  logic [2:0]              bit_cnt;
  logic [POS_W-1:0]        byte_position;
  logic [ONES_W-1:0]       ones_total;
  logic                    closing;
  logic signed [ACC_W-1:0] mul_a;
  logic [WEIGHT_W-1:0]     mul_b;
  logic [2:0]              step_cnt;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_neg;
  logic [QUO_W-1:0]        quo;
  logic [WEIGHT_W:0]       rem;
  logic [DCNT_W-1:0]       div_cnt;
  logic signed [FILT_W-1:0] filter_value;
  logic signed [PCM_W-1:0] out_data;
  logic                    out_valid;

  logic                    in_accept;
  logic                    out_free;
  logic                    count_last;
  logic                    gain_last;
  logic                    weight_last;
  logic                    div_last;
  logic [WIN_W-1:0]        win;
  logic                    close_now;
  logic [ONES_W-1:0]       ones_inc;
  logic signed [BIAS_W-1:0] bias;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        acc_abs;
  logic [WEIGHT_W:0]       divisor;
  logic [WEIGHT_W+1:0]     trial;
  logic [FMAG_W-1:0]       qmag;
  logic [11:0]             whole_mag;
  logic signed [FILT_W-1:0] filt_new;
  logic signed [PCM_W-1:0] pcm_new;

  // effective window: zero acts as one, large values saturate
  always_comb begin
    if (window_bytes == '0) begin
      win = WIN_W'(1);
    end else if (window_bytes > WIN_CW'(MAX_WINDOW_BYTES)) begin
      win = WIN_W'(MAX_WINDOW_BYTES);
    end else begin
      win = WIN_W'(window_bytes);
    end
  end

  assign close_now   = ((WIN_W + 1)'(byte_position) + (WIN_W + 1)'(1)) >= (WIN_W + 1)'(win);
  assign count_last  = (bit_cnt == 3'd7);
  assign gain_last   = (step_cnt == 3'(GAIN_W - 1));
  assign weight_last = (step_cnt == 3'(WEIGHT_W - 1));
  assign div_last    = (div_cnt == DCNT_W'(QUO_W - 1));
  assign out_free    = !out_valid || m_tready;
  assign in_accept   = s_tvalid && s_tready;

  assign ones_inc = ones_total + ONES_W'(bit_sr[0]);
  assign bias     = BIAS_W'(ones_inc) - BIAS_W'({win, 2'b00});
  assign acc_sum  = mul_b[0] ? (acc + mul_a) : acc;
  assign acc_abs  = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);

  assign divisor = {1'b0, smoothing_weight} + (WEIGHT_W + 1)'(1);
  assign trial   = {rem, quo[QUO_W-1]} - {1'b0, divisor};

  assign qmag      = (quo > QUO_W'(LIMIT)) ? LIMIT : quo[FMAG_W-1:0];
  assign whole_mag = qmag[FMAG_W-1:FRACTION_BITS];
  assign filt_new  = acc_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign pcm_new   = acc_neg ? -$signed({1'b0, whole_mag}) : $signed({1'b0, whole_mag});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_COUNT;
      end
      S_COUNT: begin
        if (count_last) begin
          if (closing) state_next = S_GAIN;
          else if (in_accept) state_next = S_COUNT;
          else state_next = S_IDLE;
        end
      end
      S_GAIN: begin
        if (gain_last) state_next = S_WEIGHT;
      end
      S_WEIGHT: begin
        if (weight_last) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    unique case (state)
      S_IDLE:  s_tready = 1'b1;
      S_COUNT: s_tready = count_last && !closing;
      default: s_tready = 1'b0;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      window_bytes     <= WINDOW_RST;
      gain             <= GAIN_RST;
      smoothing_weight <= WEIGHT_RST;
      bit_sr           <= '0;
      bit_cnt          <= '0;
      byte_position    <= '0;
      ones_total       <= '0;
      closing          <= 1'b0;
      mul_a            <= '0;
      mul_b            <= '0;
      step_cnt         <= '0;
      acc              <= '0;
      acc_neg          <= 1'b0;
      quo              <= '0;
      rem              <= '0;
      div_cnt          <= '0;
      filter_value     <= '0;
      out_data         <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW: window_bytes     <= cfg_data[WIN_CW-1:0];
          REG_GAIN:   gain             <= cfg_data[GAIN_W-1:0];
          REG_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_W-1:0];
          default:    ;
        endcase
      end

      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;

      // position advances at the request so a byte taken on the last count cycle sees it
      if (in_accept) begin
        closing       <= close_now;
        byte_position <= close_now ? '0 : byte_position + POS_W'(1);
        bit_sr        <= s_tdata;
        bit_cnt       <= '0;
      end else if (state == S_COUNT) begin
        bit_sr  <= bit_sr >> 1;
        bit_cnt <= bit_cnt + 3'd1;
      end

      case (state)
        S_COUNT: begin
          if (count_last && closing) begin
            ones_total <= '0;
            mul_a      <= ACC_W'(bias);
            mul_b      <= {1'b0, gain};
            step_cnt   <= '0;
            acc        <= '0;
          end else begin
            ones_total <= ones_inc;
          end
        end
        S_GAIN: begin
          if (gain_last) begin
            acc      <= acc_sum <<< FRACTION_BITS;
            mul_a    <= ACC_W'(filter_value);
            mul_b    <= smoothing_weight;
            step_cnt <= '0;
          end else begin
            step_cnt <= step_cnt + 3'd1;
            acc      <= acc_sum;
            mul_a    <= mul_a <<< 1;
            mul_b    <= mul_b >> 1;
          end
        end
        S_WEIGHT: begin
          step_cnt <= step_cnt + 3'd1;
          acc      <= acc_sum;
          mul_a    <= mul_a <<< 1;
          mul_b    <= mul_b >> 1;
          if (weight_last) begin
            acc_neg <= acc_sum[ACC_W-1];
            quo     <= acc_abs[QUO_W-1:0];
            rem     <= '0;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle, truncates toward zero on magnitude
          div_cnt <= div_cnt + DCNT_W'(1);
          if (!trial[WEIGHT_W+1]) begin
            rem <= trial[WEIGHT_W:0];
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            rem <= {rem[WEIGHT_W-1:0], quo[QUO_W-1]};
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
        end
        S_DONE: begin
          if (out_free) begin
            filter_value <= filt_new;
            out_data     <= pcm_new;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_request_busy, s_tready && (state == S_GAIN || state == S_WEIGHT || state == S_DIV || state == S_DONE), "request taken while a sample is in progress")
  `ASSERT_CLK(a_done_emits, (state == S_DONE && out_free) |=> out_valid, "finished sample not presented")
  `ASSERT_CLK(a_pcm_range, out_valid |-> (out_data <= 13'sd4095 && out_data >= -13'sd4095), "sample outside clamp range")
  `ASSERT_CLK(a_position_range, int'(byte_position) < MAX_WINDOW_BYTES, "byte position beyond window")

endmodule

// ===== bench/pdm_to_pcm_decimator_tb.sv =====
// self-checking testbench of the pdm to pcm decimator with a cycle-free sample predictor
`timescale 1ns / 1ps

module pdm_to_pcm_decimator_tb;
  import pdmdec_pkg::*;

  localparam int MAX_WINDOW    = 16;
  localparam int FRAC_BITS     = 8;
  localparam longint PCM_LIMIT = 64'sd4095 << FRAC_BITS;
  localparam int SETTLE_CYCLES = 96;
  localparam int HOLD_CYCLES   = 1500;
  localparam int STALL_LIMIT   = 10000;

  // predicts pcm samples from accepted pdm bytes and checks the block's output
  class pcm_scoreboard;
    logic [WIN_CW-1:0]   window_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    int unsigned         bytes_seen;
    int unsigned         ones_seen;
    longint              iir_state;
    logic [PCM_W-1:0]    pcm_queue[$];
    int                  errors;

    function new();
      window_reg = WINDOW_RST;
      gain_reg   = GAIN_RST;
      weight_reg = WEIGHT_RST;
      bytes_seen = 0;
      ones_seen  = 0;
      iir_state  = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WINDOW: window_reg = val[WIN_CW-1:0];
        REG_GAIN:   gain_reg   = val[GAIN_W-1:0];
        REG_WEIGHT: weight_reg = val[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [PDM_W-1:0] pdm);
      int unsigned win;
      longint sample;
      longint w;
      longint acc;
      longint whole;
      if (window_reg == 0) win = 1;
      else if (window_reg > MAX_WINDOW) win = MAX_WINDOW;
      else win = 32'(window_reg);
      ones_seen += $countones(pdm);
      if (bytes_seen + 1 < win) begin
        bytes_seen++;
        return;
      end
      sample = (longint'(ones_seen) - longint'(win) * 4) * longint'(gain_reg);
      bytes_seen = 0;
      ones_seen  = 0;
      w = longint'(weight_reg);
      acc = sample * (64'sd1 << FRAC_BITS) + iir_state * w;
      iir_state = acc / (w + 1);
      if (iir_state > PCM_LIMIT) iir_state = PCM_LIMIT;
      if (iir_state < -PCM_LIMIT) iir_state = -PCM_LIMIT;
      whole = iir_state / (64'sd1 << FRAC_BITS);
      pcm_queue.push_back(whole[PCM_W-1:0]);
    endfunction

    function int pending();
      return pcm_queue.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [PCM_W-1:0] got);
      logic [PCM_W-1:0] want;
      if (pcm_queue.size() == 0) begin
        report($sformatf("unexpected pcm_sample %0d", $signed(got)));
        return;
      end
      want = pcm_queue.pop_front();
      if (got !== want)
        report($sformatf("pcm_sample got %0d want %0d", $signed(got), $signed(want)));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [PDM_W-1:0]    s_tdata;   // [7:0] pdm_byte
  logic                m_tvalid;
  logic                m_tready;
  logic [15:0]         m_tdata;   // [12:0] pcm_sample, [15:13] zero
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  pcm_scoreboard sb = new();
  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  bit  rx_hold_req  = 1'b0;
  int  quiet_cycles = 0;

  always #2 clk = ~clk;

  pdm_to_pcm_decimator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // output first: a result taken at this edge belongs to an earlier byte
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata[PCM_W-1:0]);
      if (s_tvalid && s_tready) sb.note_input(s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  function automatic logic [PDM_W-1:0] pdm_pattern(int density);
    logic [PDM_W-1:0] bits;
    for (int k = 0; k < PDM_W; k++) bits[k] = ($urandom_range(0, 99) < density);
    return bits;
  endfunction

  task automatic send_byte(logic [PDM_W-1:0] pdm);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pdm;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // wait for every sample, then for the block to finish a non-closing byte
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [WIN_CW-1:0] win, logic [GAIN_W-1:0] gain,
                                logic [WEIGHT_W-1:0] weight);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_data  <= CFG_W'(win);
    @(posedge clk);
    sb.set_reg(REG_WINDOW, CFG_W'(win));
    cfg_index <= REG_GAIN;
    cfg_data  <= CFG_W'(gain);
    @(posedge clk);
    sb.set_reg(REG_GAIN, CFG_W'(gain));
    cfg_index <= REG_WEIGHT;
    cfg_data  <= weight;
    @(posedge clk);
    sb.set_reg(REG_WEIGHT, weight);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n_items, int mode, bit long_hold, bit drain_pause);
    int density;
    int run_left;
    logic [PDM_W-1:0] pdm;
    tx_idle_pct  = (mode == 1) ? 64 : (mode == 3) ? 14 : 0;
    rx_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 14 : 0;
    if (long_hold) rx_hold_req = 1'b1;
    density  = 50;
    run_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0: density = 0;
          1: density = 100;
          default: density = $urandom_range(0, 100);
        endcase
        run_left = $urandom_range(1, 16);
      end
      run_left--;
      if ($urandom_range(0, 4) == 0) pdm = PDM_W'($urandom_range(0, 255));
      else pdm = pdm_pattern(density);
      if (drain_pause && i == n_items / 2) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_byte(pdm);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [WIN_CW-1:0] win;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default window, then shrink it below the current position
    send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(8'h01);
    settle();
    apply_settings(5'd2, 7'd1, 8'd7);
    send_byte(8'h80);
    settle();
    // zero window acts as one, zero weight takes the sample as is
    apply_settings(5'd0, 7'd127, 8'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    settle();
    apply_settings(5'd0, 7'd0, 8'd0);
    send_byte(8'hAA);
    settle();
    // oversized window acts as the maximum, drives the negative clamp
    apply_settings(5'd31, 7'd127, 8'd0);
    repeat (16) send_byte(8'h00);
    settle();

    apply_settings(5'd1, 7'd64, 8'd255);
    run_phase(60, 0, 1'b0, 1'b0);
    settle();
    apply_settings(5'd0, 7'd0, 8'd0);
    run_phase(60, 1, 1'b0, 1'b0);
    settle();
    apply_settings(5'd4, 7'd127, 8'd0);
    run_phase(60, 2, 1'b1, 1'b0);
    settle();
    apply_settings(5'd31, 7'd127, 8'd1);
    run_phase(60, 3, 1'b0, 1'b0);
    settle();
    for (int p = 4; p < 9; p++) begin
      if ($urandom_range(0, 9) < 7) win = WIN_CW'($urandom_range(1, 6));
      else win = WIN_CW'($urandom_range(0, 31));
      apply_settings(win, GAIN_W'($urandom_range(0, 127)),
                     WEIGHT_W'($urandom_range(0, 255)));
      run_phase(60, p % 4, 1'b0, p == 5);
      settle();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
